// File: hw/rtl/dxt_block_texture_decoder_top_macros.svh
// assertion macros for the dxt block texture decoder top level
// no dependencies; included by the top level only
`ifndef DXT_BLOCK_TEXTURE_DECODER_TOP_MACROS_SVH
`define DXT_BLOCK_TEXTURE_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define DXT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dxt assertion failed");

// next-cycle implication, disabled in reset
`define DXT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dxt assertion failed");

`endif

// File: hw/rtl/dxt_pkg.sv
// shared types, constants and arithmetic helpers for the dxt block decoder
// no dependencies; imported by every rtl module of the block
package dxt_pkg;

   // image and position geometry
   localparam int MAX_DIMENSION     = 8192;
   localparam int DIM_WIDTH         = 14;
   localparam int POS_WIDTH         = 13;
   localparam int BLOCK_POS_WIDTH   = 11;
   localparam int BLOCK_COUNT_WIDTH = 12;
   localparam int ROW_WIDTH         = 2;
   localparam int LANES             = 4;
   localparam int PALETTE_SIZE      = 4;
   localparam int ALPHA_LEVELS      = 8;
   localparam int DXT5_INDEX_BASE   = 16;

   localparam logic [ROW_WIDTH-1:0] LAST_ROW    = ROW_WIDTH'(LANES - 1);
   localparam logic [DIM_WIDTH-1:0] DIM_RESET   = DIM_WIDTH'(4);
   localparam logic [DIM_WIDTH-1:0] DIM_LIMIT   = DIM_WIDTH'(MAX_DIMENSION);
   localparam logic [7:0]           ALPHA_OPAQUE = 8'hFF;

   // register file
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 14;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEIGHT = 2'd2;

   // compression modes
   localparam logic [1:0] MODE_DXT1 = 2'd0;
   localparam logic [1:0] MODE_DXT3 = 2'd1;
   localparam logic [1:0] MODE_DXT5 = 2'd2;

   // reciprocal constants for truncating division by 3, 5 and 7 (16-bit shift)
   localparam logic [15:0] DIV3_MAGIC = 16'd21846;
   localparam logic [15:0] DIV5_MAGIC = 16'd13108;
   localparam logic [15:0] DIV7_MAGIC = 16'd9363;

   typedef struct packed {
      logic [63:0] alpha_word;
      logic [63:0] color_bits;
   } req_data_type;

   typedef struct packed {
      logic [31:0]          texel_zero;
      logic [31:0]          texel_one;
      logic [31:0]          texel_two;
      logic [31:0]          texel_three;
      logic [POS_WIDTH-1:0] pos_x;
      logic [POS_WIDTH-1:0] pos_y;
      logic [LANES-1:0]     inside_mask;
      logic                 last_row;
   } rsp_data_type;

   // per-block color palette and alpha levels
   typedef struct packed {
      logic [PALETTE_SIZE-1:0][31:0] colors;
      logic [ALPHA_LEVELS-1:0][7:0]  alphas;
   } dxt_palette_type;

   // per-texel selectors handed to one lane
   typedef struct packed {
      logic [1:0] color_index;
      logic [3:0] alpha_nibble;
      logic [2:0] alpha_index;
   } dxt_sel_type;

   // 5-bit and 6-bit channel expansion, c*255/max truncated
   function automatic logic [31:0][7:0] build_expand5();
      logic [31:0][7:0] t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 8'((i * 255) / 31);
      end
      return t;
   endfunction

   function automatic logic [63:0][7:0] build_expand6();
      logic [63:0][7:0] t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 8'((i * 255) / 63);
      end
      return t;
   endfunction

   localparam logic [31:0][7:0] EXPAND5_LUT = build_expand5();
   localparam logic [63:0][7:0] EXPAND6_LUT = build_expand6();

   // x/3 for x below 768, result fits 8 bits
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [25:0] p;
      p = 26'(x) * 26'(DIV3_MAGIC);
      return p[23:16];
   endfunction

   // x/5 for x below 2048, result known to fit 8 bits
   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [26:0] p;
      p = 27'(x) * 27'(DIV5_MAGIC);
      return p[23:16];
   endfunction

   // x/7 for x below 2048, result known to fit 8 bits
   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [26:0] p;
      p = 27'(x) * 27'(DIV7_MAGIC);
      return p[23:16];
   endfunction

endpackage

// File: hw/rtl/dxt_palette.sv
// block palette builder: endpoint expansion, color interpolation, dxt5 alpha levels
// depends on dxt_pkg
module dxt_palette import dxt_pkg::*; (
   input  logic [1:0]      mode,
   input  logic [63:0]     alpha_word,
   input  logic [31:0]     endpoints,
   output dxt_palette_type palette
);

   logic [15:0] c0;
   logic [15:0] c1;
   logic [7:0]  e0 [3];
   logic [7:0]  e1 [3];
   logic [7:0]  m2 [3];
   logic [7:0]  m3 [3];
   logic        four_color;
   logic [7:0]  a0;
   logic [7:0]  a1;

   assign c0 = endpoints[15:0];
   assign c1 = endpoints[31:16];
   assign a0 = alpha_word[7:0];
   assign a1 = alpha_word[15:8];

   // rgb565 expansion, channel 0 red, 1 green, 2 blue
   always_comb begin
      e0[0] = EXPAND5_LUT[c0[15:11]];
      e0[1] = EXPAND6_LUT[c0[10:5]];
      e0[2] = EXPAND5_LUT[c0[4:0]];
      e1[0] = EXPAND5_LUT[c1[15:11]];
      e1[1] = EXPAND6_LUT[c1[10:5]];
      e1[2] = EXPAND5_LUT[c1[4:0]];
   end

   // dxt1 with c0 <= c1 falls back to three colors plus transparent black
   assign four_color = (mode != MODE_DXT1) || (c0 > c1);

   // interpolated colors
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (four_color) begin
            m2[c] = div3({1'b0, e0[c], 1'b0} + {2'b00, e1[c]});
         end else begin
            m2[c] = 8'(({1'b0, e0[c]} + {1'b0, e1[c]}) >> 1);
         end
         m3[c] = div3({2'b00, e0[c]} + {1'b0, e1[c], 1'b0});
      end
   end

   // pack colors as rgba, dxt5 alpha levels: eight-level or six-level plus zero and full
   always_comb begin
      palette.colors[0] = {ALPHA_OPAQUE, e0[2], e0[1], e0[0]};
      palette.colors[1] = {ALPHA_OPAQUE, e1[2], e1[1], e1[0]};
      palette.colors[2] = {ALPHA_OPAQUE, m2[2], m2[1], m2[0]};
      palette.colors[3] = four_color ? {ALPHA_OPAQUE, m3[2], m3[1], m3[0]} : 32'd0;
      palette.alphas[0] = a0;
      palette.alphas[1] = a1;
      if (a0 > a1) begin
         for (int i = 2; i < ALPHA_LEVELS; i++) begin
            palette.alphas[i] = div7(11'(8 - i) * 11'(a0) + 11'(i - 1) * 11'(a1));
         end
      end else begin
         for (int i = 2; i < 6; i++) begin
            palette.alphas[i] = div5(11'(6 - i) * 11'(a0) + 11'(i - 1) * 11'(a1));
         end
         palette.alphas[6] = 8'd0;
         palette.alphas[7] = ALPHA_OPAQUE;
      end
   end

endmodule

// File: hw/rtl/dxt_lane.sv
// one texel lane: palette lookup and alpha replacement for a single texel
// depends on dxt_pkg
module dxt_lane import dxt_pkg::*; (
   input  logic [1:0]      mode,
   input  dxt_palette_type palette,
   input  dxt_sel_type     sel,
   output logic [31:0]     texel
);

   // color from palette, alpha from the mode's alpha source
   always_comb begin
      texel = palette.colors[sel.color_index];
      unique case (mode)
         MODE_DXT3: begin
            texel[31:24] = {sel.alpha_nibble, sel.alpha_nibble};
         end
         MODE_DXT5: begin
            texel[31:24] = palette.alphas[sel.alpha_index];
         end
         default: begin
         end
      endcase
   end

endmodule

// File: hw/rtl/dxt_block_texture_decoder_top.sv
// dxt block texture decoder top: block intake, palette stage, four texel lanes, row merge
// flow: a block passes the intake and palette registers, and its rows then leave one at
// a time through the single row-wide output register; rsp_ready low holds the rows
// reset: synchronous; clears valids, row and block counters, sets configuration registers to power-on values
// depends on dxt_pkg, dxt_palette, dxt_lane and the assertion macro header
`include "dxt_block_texture_decoder_top_macros.svh"

module dxt_block_texture_decoder_top import dxt_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_data_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_data_type               rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // configuration registers
   logic [1:0]           mode_ff, mode_in;
   logic [DIM_WIDTH-1:0] image_width_ff, image_width_in;
   logic [DIM_WIDTH-1:0] image_height_ff, image_height_in;

   // block position counters
   logic [BLOCK_POS_WIDTH-1:0] block_col_ff, block_col_in;
   logic [BLOCK_POS_WIDTH-1:0] block_row_ff, block_row_in;

   // intake stage
   logic                       in_valid_ff, in_valid_in;
   req_data_type               in_data_ff, in_data_in;
   logic [BLOCK_POS_WIDTH-1:0] in_col_ff, in_col_in;
   logic [BLOCK_POS_WIDTH-1:0] in_row_ff, in_row_in;

   // palette stage
   logic                       pal_valid_ff, pal_valid_in;
   dxt_palette_type            pal_ff, pal_in;
   logic [1:0]                 pal_mode_ff, pal_mode_in;
   logic [31:0]                pal_cidx_ff, pal_cidx_in;
   logic [63:0]                pal_alpha_ff, pal_alpha_in;
   logic [BLOCK_POS_WIDTH-1:0] pal_col_ff, pal_col_in;
   logic [BLOCK_POS_WIDTH-1:0] pal_row_ff, pal_row_in;
   logic [ROW_WIDTH-1:0]       row_ff, row_in;

   // output register
   logic         out_valid_ff, out_valid_in;
   rsp_data_type out_ff, out_in;

   // handshake and derived signals
   logic                         req_fire;
   logic                         row_fire;
   logic                         row_done;
   logic                         pal_free;
   logic                         in_move;
   logic [1:0]                   eff_mode;
   logic [DIM_WIDTH-1:0]         w_sat;
   logic [DIM_WIDTH-1:0]         h_sat;
   logic [BLOCK_COUNT_WIDTH-1:0] blocks_per_row;
   logic [BLOCK_COUNT_WIDTH-1:0] block_rows;
   logic [BLOCK_COUNT_WIDTH-1:0] col_next;
   logic [BLOCK_COUNT_WIDTH-1:0] row_next;
   dxt_palette_type              pal_build;
   dxt_sel_type                  lane_sel [LANES];
   logic [31:0]                  lane_texel [LANES];
   logic [LANES-1:0]             in_image;
   logic [POS_WIDTH-1:0]         row_x0;
   logic [POS_WIDTH-1:0]         row_y;

   // pipeline flow control
   assign row_fire  = pal_valid_ff && (!out_valid_ff || rsp_ready);
   assign row_done  = row_fire && (row_ff == LAST_ROW);
   assign pal_free  = !pal_valid_ff || row_done;
   assign in_move   = in_valid_ff && pal_free;
   assign req_ready = !in_valid_ff || pal_free;
   assign req_fire  = req_valid && req_ready;

   // configuration write decode
   always_comb begin
      mode_in         = mode_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:   mode_in         = csr_wdata[1:0];
            CSR_WIDTH:  image_width_in  = csr_wdata;
            CSR_HEIGHT: image_height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // undefined mode code behaves as dxt1
   always_comb begin
      unique case (mode_ff) inside
         MODE_DXT3, MODE_DXT5: eff_mode = mode_ff;
         default:              eff_mode = MODE_DXT1;
      endcase
   end

   // saturated dimensions and block counts, zero counts as one
   always_comb begin
      w_sat = (image_width_ff > DIM_LIMIT) ? DIM_LIMIT : image_width_ff;
      h_sat = (image_height_ff > DIM_LIMIT) ? DIM_LIMIT : image_height_ff;
      blocks_per_row = BLOCK_COUNT_WIDTH'(({1'b0, w_sat} + (DIM_WIDTH + 1)'(3)) >> 2);
      block_rows     = BLOCK_COUNT_WIDTH'(({1'b0, h_sat} + (DIM_WIDTH + 1)'(3)) >> 2);
      if (blocks_per_row == '0) begin
         blocks_per_row = BLOCK_COUNT_WIDTH'(1);
      end
      if (block_rows == '0) begin
         block_rows = BLOCK_COUNT_WIDTH'(1);
      end
   end

   // block position advance on each input transfer
   always_comb begin
      block_col_in = block_col_ff;
      block_row_in = block_row_ff;
      col_next     = BLOCK_COUNT_WIDTH'(block_col_ff) + BLOCK_COUNT_WIDTH'(1);
      row_next     = BLOCK_COUNT_WIDTH'(block_row_ff) + BLOCK_COUNT_WIDTH'(1);
      if (req_fire) begin
         if (col_next >= blocks_per_row) begin
            block_col_in = '0;
            block_row_in = (row_next >= block_rows) ? '0 : row_next[BLOCK_POS_WIDTH-1:0];
         end else begin
            block_col_in = col_next[BLOCK_POS_WIDTH-1:0];
         end
      end
   end

   // intake stage next state
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      if (in_move) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
         in_col_in   = block_col_ff;
         in_row_in   = block_row_ff;
      end
   end

   // palette build for the block in the intake stage
   dxt_palette u_palette (
      .mode       (eff_mode),
      .alpha_word (in_data_ff.alpha_word),
      .endpoints  (in_data_ff.color_bits[31:0]),
      .palette    (pal_build)
   );

   // palette stage next state and row sequencer
   always_comb begin
      pal_valid_in = pal_valid_ff;
      pal_in       = pal_ff;
      pal_mode_in  = pal_mode_ff;
      pal_cidx_in  = pal_cidx_ff;
      pal_alpha_in = pal_alpha_ff;
      pal_col_in   = pal_col_ff;
      pal_row_in   = pal_row_ff;
      row_in       = row_fire ? row_ff + ROW_WIDTH'(1) : row_ff;
      if (row_done) begin
         pal_valid_in = 1'b0;
      end
      if (in_move) begin
         pal_valid_in = 1'b1;
         pal_in       = pal_build;
         pal_mode_in  = eff_mode;
         pal_cidx_in  = in_data_ff.color_bits[63:32];
         pal_alpha_in = in_data_ff.alpha_word;
         pal_col_in   = in_col_ff;
         pal_row_in   = in_row_ff;
      end
   end

   // per-lane texel selectors for the current row
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         logic [3:0] ti;
         logic [6:0] abit;
         ti   = {row_ff, 2'(k)};
         abit = 7'(DXT5_INDEX_BASE) + 7'({ti, 1'b0}) + 7'(ti);
         lane_sel[k].color_index  = pal_cidx_ff[{ti, 1'b0} +: 2];
         lane_sel[k].alpha_nibble = pal_alpha_ff[{ti, 2'b00} +: 4];
         lane_sel[k].alpha_index  = pal_alpha_ff[abit[5:0] +: 3];
      end
   end

   // texel lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      dxt_lane u_lane (
         .mode    (pal_mode_ff),
         .palette (pal_ff),
         .sel     (lane_sel[g]),
         .texel   (lane_texel[g])
      );
   end

   // row clipping against the image
   always_comb begin
      row_x0 = {pal_col_ff, 2'b00};
      row_y  = {pal_row_ff, row_ff};
      for (int k = 0; k < LANES; k++) begin
         in_image[k] = (({1'b0, row_x0} + DIM_WIDTH'(k)) < w_sat) && ({1'b0, row_y} < h_sat);
      end
   end

   // merge lanes into the output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (row_fire) begin
         out_valid_in       = 1'b1;
         out_in.texel_zero  = lane_texel[0] & {32{in_image[0]}};
         out_in.texel_one   = lane_texel[1] & {32{in_image[1]}};
         out_in.texel_two   = lane_texel[2] & {32{in_image[2]}};
         out_in.texel_three = lane_texel[3] & {32{in_image[3]}};
         out_in.pos_x       = row_x0;
         out_in.pos_y       = row_y;
         out_in.inside_mask = in_image;
         out_in.last_row    = (row_ff == LAST_ROW);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_DXT1;
         image_width_ff  <= DIM_RESET;
         image_height_ff <= DIM_RESET;
         block_col_ff    <= '0;
         block_row_ff    <= '0;
         in_valid_ff     <= 1'b0;
         pal_valid_ff    <= 1'b0;
         row_ff          <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         block_col_ff    <= block_col_in;
         block_row_ff    <= block_row_in;
         in_valid_ff     <= in_valid_in;
         pal_valid_ff    <= pal_valid_in;
         row_ff          <= row_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff   <= in_data_in;
      in_col_ff    <= in_col_in;
      in_row_ff    <= in_row_in;
      pal_ff       <= pal_in;
      pal_mode_ff  <= pal_mode_in;
      pal_cidx_ff  <= pal_cidx_in;
      pal_alpha_ff <= pal_alpha_in;
      pal_col_ff   <= pal_col_in;
      pal_row_ff   <= pal_row_in;
      out_ff       <= out_in;
   end

   // checks on the row sequencer and result coherence
   `DXT_ASSERT_NEXT(a_row_wrap, clock, reset, row_done, row_ff == '0)
   `DXT_ASSERT_IMPLY(a_last_row_pos, clock, reset, rsp_valid, rsp_data.last_row == (rsp_data.pos_y[1:0] == LAST_ROW))
   `DXT_ASSERT_IMPLY(a_clip_zero, clock, reset, rsp_valid, (rsp_data.inside_mask[0] || rsp_data.texel_zero == '0) && (rsp_data.inside_mask[3] || rsp_data.texel_three == '0))
   `DXT_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !pal_valid_ff, req_ready)

endmodule
